// File: src/zdf_ladder_lowpass_unit_defines.svh
// Assertion macros shared by the checker of the ladder lowpass unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ZDF_LADDER_LOWPASS_UNIT_DEFINES_SVH
`define ZDF_LADDER_LOWPASS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ZLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ZLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/zlp_pkg.sv
// Package of the ladder lowpass unit: formats, codes, sequencer states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package zlp_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int IN_SH        = 28 - SAMPLE_WIDTH;
  localparam int OUT_SH       = 28 - SAMPLE_WIDTH;

  localparam logic [31:0] SCALE_RESET = 32'd280962;
  localparam logic [30:0] COEF_ONE    = 31'h4000_0000;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_N_W = 63;
  localparam int DIV_D_W = 49;
  localparam int DIV_Q_W = 32;

  // Rounding shift applied by the shared multiplier.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_K,
    SH_C
  } zlp_shift_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } zlp_state_t;

  // Multiply steps of one item, in order.
  localparam logic [4:0] OP_F    = 5'd0;
  localparam logic [4:0] OP_G2   = 5'd1;
  localparam logic [4:0] OP_G3   = 5'd2;
  localparam logic [4:0] OP_G4   = 5'd3;
  localparam logic [4:0] OP_S0   = 5'd4;
  localparam logic [4:0] OP_S1   = 5'd5;
  localparam logic [4:0] OP_S2   = 5'd6;
  localparam logic [4:0] OP_KS   = 5'd7;
  localparam logic [4:0] OP_KG   = 5'd8;
  localparam logic [4:0] OP_STG  = 5'd9;
  localparam logic [4:0] OP_LAST = 5'd16;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/zlp_mulr.sv
// Shared signed multiplier with rounding right shift and output register.
// Depends on zlp_pkg.
`timescale 1ns / 1ps

module zlp_mulr (
  input  logic                                 clk,
  input  logic signed [zlp_pkg::MUL_A_W-1:0]  a,
  input  logic signed [zlp_pkg::MUL_B_W-1:0]  b,
  input  zlp_pkg::zlp_shift_t                  sh,
  output logic signed [63:0]                   res_r
);

  logic signed [zlp_pkg::MUL_P_W-1:0] prod;
  logic        [zlp_pkg::MUL_P_W-1:0] mag;
  logic        [zlp_pkg::MUL_P_W-1:0] shv;
  logic        [63:0]                 low;
  logic signed [63:0]                 res_nxt;

  always_comb begin
    prod = a * b;
    mag  = prod[zlp_pkg::MUL_P_W-1] ? zlp_pkg::MUL_P_W'(-prod) : zlp_pkg::MUL_P_W'(prod);
    // Round half away from zero on the magnitude.
    unique case (sh)
      zlp_pkg::SH_K: shv = (mag + (zlp_pkg::MUL_P_W'(1) << 12)) >> 13;
      zlp_pkg::SH_C: shv = (mag + (zlp_pkg::MUL_P_W'(1) << 29)) >> 30;
      default:       shv = mag;
    endcase
    low     = shv[63:0];
    res_nxt = prod[zlp_pkg::MUL_P_W-1] ? $signed(64'(-low)) : $signed(low);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: src/zlp_div.sv
// Restoring unsigned divider, one quotient bit per cycle, 32 quotient bits a run.
// The dividend's top bits must be below the divisor. Depends on zlp_pkg.
`timescale 1ns / 1ps

module zlp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [zlp_pkg::DIV_N_W-1:0]   dividend,
  input  logic [zlp_pkg::DIV_D_W-1:0]   divisor,
  output logic                          done_r,
  output logic [zlp_pkg::DIV_Q_W-1:0]   quo_r
);

  logic                           busy_r;
  logic [4:0]                     cnt_r;
  logic [zlp_pkg::DIV_D_W-1:0]    rem_r;
  logic [zlp_pkg::DIV_D_W-1:0]    den_r;
  logic [zlp_pkg::DIV_Q_W-1:0]    low_r;
  logic [zlp_pkg::DIV_D_W:0]      trial;
  logic                           fits;

  always_comb begin
    trial = {rem_r, low_r[zlp_pkg::DIV_Q_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= zlp_pkg::DIV_D_W'(dividend[zlp_pkg::DIV_N_W-1:zlp_pkg::DIV_Q_W]);
      low_r <= dividend[zlp_pkg::DIV_Q_W-1:0];
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? zlp_pkg::DIV_D_W'(trial - {1'b0, den_r}) : trial[zlp_pkg::DIV_D_W-1:0];
      low_r <= {low_r[zlp_pkg::DIV_Q_W-2:0], 1'b0};
      quo_r <= {quo_r[zlp_pkg::DIV_Q_W-2:0], fits};
    end
  end

endmodule

// File: src/zdf_ladder_lowpass_unit.sv
// Top level of the four-stage zero-delay-feedback ladder lowpass.
// Depends on zlp_pkg, zlp_mulr and zlp_div.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid/in_ready, audio_in, cutoff_hz, resonance
//   out     | output    | out_valid/out_ready, audio_out
//   cfg     | input     | cfg_valid/cfg_ready, cutoff_scale
//
// An item takes 17 multiplies on the one shared multiplier and two runs of the
// serial divider.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// A finished item waits in the output register; a stalled out_ready holds the
// sequencer in its last step. Synchronous reset clears the four stage states.
`timescale 1ns / 1ps

module zdf_ladder_lowpass_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [zlp_pkg::SAMPLE_WIDTH-1:0]  in_audio_in,
  input  logic        [15:0]                        in_cutoff_hz,
  input  logic        [14:0]                        in_resonance,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [zlp_pkg::SAMPLE_WIDTH-1:0]  out_audio_out,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic        [31:0]                        cfg_cutoff_scale
);

  zlp_pkg::zlp_state_t state_r, state_nxt;

  logic [4:0]         op_r;
  logic [31:0]        scale_r;
  logic signed [31:0] x_r;
  logic [15:0]        hz_r;
  logic [14:0]        kq_r;
  logic [47:0]        f_r;
  logic [30:0]        v_r;
  logic [30:0]        g_r;
  logic [30:0]        gp_r;
  logic signed [35:0] t_r;
  logic signed [31:0] num_r;
  logic [32:0]        den_r;
  logic signed [35:0] y_r;
  logic signed [35:0] acc_r;
  logic signed [31:0] s_r [4];

  logic                              out_valid_r;
  logic signed [zlp_pkg::SAMPLE_WIDTH-1:0] out_audio_r;

  // Sequencer outputs.
  logic in_take;
  logic cap_en;
  logic div_start;
  logic out_load;

  // Multiplier and divider.
  logic signed [zlp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [zlp_pkg::MUL_B_W-1:0] mul_b;
  zlp_pkg::zlp_shift_t                mul_sh;
  logic signed [63:0]                 mul_r;
  logic [zlp_pkg::DIV_N_W-1:0]        div_n;
  logic [zlp_pkg::DIV_D_W-1:0]        div_d;
  logic                               div_done;
  logic [zlp_pkg::DIV_Q_W-1:0]        div_q;

  logic [4:0]         st;
  logic [1:0]         si;
  logic [48:0]        den_f;
  logic [31:0]        nmag;
  logic signed [31:0] ynew;
  logic signed [31:0] snew;
  logic signed [31:0] yv;
  logic [31:0]        omag;
  logic [31:0]        orr;
  logic signed [32:0] os;
  logic signed [zlp_pkg::SAMPLE_WIDTH-1:0] osat;

  assign st = op_r - zlp_pkg::OP_STG;
  assign si = st[2:1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zlp_pkg::ST_IDLE:   if (in_valid) state_nxt = zlp_pkg::ST_ISSUE;
      zlp_pkg::ST_ISSUE:  state_nxt = zlp_pkg::ST_WAIT;
      zlp_pkg::ST_WAIT: begin
        if (op_r == zlp_pkg::OP_F || op_r == zlp_pkg::OP_KG) begin
          state_nxt = zlp_pkg::ST_DSTART;
        end else if (op_r == zlp_pkg::OP_LAST) begin
          state_nxt = zlp_pkg::ST_OUT;
        end else begin
          state_nxt = zlp_pkg::ST_ISSUE;
        end
      end
      zlp_pkg::ST_DSTART: state_nxt = zlp_pkg::ST_DWAIT;
      zlp_pkg::ST_DWAIT:  if (div_done) state_nxt = zlp_pkg::ST_ISSUE;
      zlp_pkg::ST_OUT:    if (!out_valid_r || out_ready) state_nxt = zlp_pkg::ST_IDLE;
      default:            state_nxt = zlp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = state_r == zlp_pkg::ST_IDLE;
    in_take   = in_ready && in_valid;
    cap_en    = state_r == zlp_pkg::ST_WAIT;
    div_start = state_r == zlp_pkg::ST_DSTART;
    out_load  = (state_r == zlp_pkg::ST_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zlp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = zlp_pkg::SH_C;
    unique case (op_r)
      zlp_pkg::OP_F: begin
        mul_a  = zlp_pkg::MUL_A_W'(scale_r);
        mul_b  = zlp_pkg::MUL_B_W'(hz_r);
        mul_sh = zlp_pkg::SH_NONE;
      end
      zlp_pkg::OP_G2: begin
        mul_a = zlp_pkg::MUL_A_W'(g_r);
        mul_b = zlp_pkg::MUL_B_W'(g_r);
      end
      zlp_pkg::OP_G3, zlp_pkg::OP_G4: begin
        mul_a = zlp_pkg::MUL_A_W'(gp_r);
        mul_b = zlp_pkg::MUL_B_W'(g_r);
      end
      zlp_pkg::OP_S0: begin
        mul_a = zlp_pkg::MUL_A_W'(s_r[0]);
        mul_b = zlp_pkg::MUL_B_W'(g_r);
      end
      zlp_pkg::OP_S1, zlp_pkg::OP_S2: begin
        mul_a = t_r;
        mul_b = zlp_pkg::MUL_B_W'(g_r);
      end
      zlp_pkg::OP_KS: begin
        mul_a  = t_r;
        mul_b  = zlp_pkg::MUL_B_W'(kq_r);
        mul_sh = zlp_pkg::SH_K;
      end
      zlp_pkg::OP_KG: begin
        mul_a  = zlp_pkg::MUL_A_W'(gp_r);
        mul_b  = zlp_pkg::MUL_B_W'(kq_r);
        mul_sh = zlp_pkg::SH_K;
      end
      default: begin
        // Ladder stages: g times the stage input, then v times the state.
        if (!st[0]) begin
          mul_a = y_r;
          mul_b = zlp_pkg::MUL_B_W'(g_r);
        end else begin
          mul_a = zlp_pkg::MUL_A_W'(s_r[si]);
          mul_b = zlp_pkg::MUL_B_W'(v_r);
        end
      end
    endcase
  end

  zlp_mulr u_mulr (
    .clk   (clk),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .res_r (mul_r)
  );

  // Divider operands: first v = 2^62 / (2^32 + f), then |num| * 2^30 / den.
  always_comb begin
    den_f = 49'(f_r) + (49'(1) << 32);
    nmag  = num_r[31] ? 32'(-num_r) : 32'(num_r);
    if (op_r == zlp_pkg::OP_G2) begin
      div_n = (63'(1) << 62) + 63'(den_f >> 1);
      div_d = den_f;
    end else begin
      div_n = (63'(nmag) << 30) + 63'(den_r >> 1);
      div_d = 49'(den_r);
    end
  end

  zlp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done_r   (div_done),
    .quo_r    (div_q)
  );

  // Stage update from the accumulated g*y term and the v*s product.
  always_comb begin
    ynew = zlp_pkg::sat32(64'(acc_r) + mul_r);
    snew = zlp_pkg::sat32((64'(ynew) <<< 1) - 64'(s_r[si]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= '0;
      scale_r <= zlp_pkg::SCALE_RESET;
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        scale_r <= cfg_cutoff_scale;
      end
      if (in_take) begin
        op_r <= zlp_pkg::OP_F;
      end else if (cap_en) begin
        op_r <= op_r + 5'd1;
      end
      if (cap_en && op_r >= zlp_pkg::OP_STG && st[0]) begin
        s_r[si] <= snew;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r  <= 32'(in_audio_in) <<< zlp_pkg::IN_SH;
      hz_r <= in_cutoff_hz;
      kq_r <= in_resonance;
    end
    if (state_r == zlp_pkg::ST_DWAIT && div_done) begin
      if (op_r == zlp_pkg::OP_G2) begin
        v_r <= div_q[30:0];
        g_r <= zlp_pkg::COEF_ONE - div_q[30:0];
      end else begin
        y_r <= num_r[31] ? -$signed({4'b0, div_q}) : $signed({4'b0, div_q});
      end
    end
    if (cap_en) begin
      unique case (op_r)
        zlp_pkg::OP_F:  f_r <= mul_r[47:0];
        zlp_pkg::OP_G2, zlp_pkg::OP_G3, zlp_pkg::OP_G4: gp_r <= mul_r[30:0];
        zlp_pkg::OP_S0: t_r <= 36'(s_r[1]) + $signed(mul_r[35:0]);
        zlp_pkg::OP_S1: t_r <= 36'(s_r[2]) + $signed(mul_r[35:0]);
        zlp_pkg::OP_S2: t_r <= 36'(s_r[3]) + $signed(mul_r[35:0]);
        zlp_pkg::OP_KS: num_r <= zlp_pkg::sat32(64'(x_r) - mul_r);
        zlp_pkg::OP_KG: den_r <= 33'(zlp_pkg::COEF_ONE) + mul_r[32:0];
        default: begin
          if (!st[0]) begin
            acc_r <= $signed(mul_r[35:0]);
          end else begin
            y_r <= 36'(ynew);
          end
        end
      endcase
    end
  end

  // Last stage to sample format, rounded and saturated.
  always_comb begin
    yv   = y_r[31:0];
    omag = yv[31] ? 32'(-yv) : 32'(yv);
    orr  = (omag + (32'(1) << (zlp_pkg::OUT_SH - 1))) >> zlp_pkg::OUT_SH;
    os   = yv[31] ? -$signed({1'b0, orr}) : $signed({1'b0, orr});
    if (os > $signed(33'((64'(1) << (zlp_pkg::SAMPLE_WIDTH - 1)) - 64'(1)))) begin
      osat = {1'b0, {(zlp_pkg::SAMPLE_WIDTH - 1){1'b1}}};
    end else if (os < -$signed(33'(64'(1) << (zlp_pkg::SAMPLE_WIDTH - 1)))) begin
      osat = {1'b1, {(zlp_pkg::SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      osat = os[zlp_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_audio_r <= osat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_audio_r;
  assign cfg_ready     = 1'b1;

endmodule

// File: src/zlp_checker.sv
// Port-level checker of the ladder lowpass unit, bound to the top level.
// Depends on zdf_ladder_lowpass_unit_defines.svh and zlp_pkg.
`timescale 1ns / 1ps
`include "zdf_ladder_lowpass_unit_defines.svh"

module zlp_checker (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_valid,
  input logic                                      in_ready,
  input logic signed [zlp_pkg::SAMPLE_WIDTH-1:0]  in_audio_in,
  input logic        [15:0]                        in_cutoff_hz,
  input logic        [14:0]                        in_resonance,
  input logic                                      out_valid,
  input logic                                      out_ready,
  input logic signed [zlp_pkg::SAMPLE_WIDTH-1:0]  out_audio_out,
  input logic                                      cfg_valid,
  input logic                                      cfg_ready,
  input logic        [31:0]                        cfg_cutoff_scale
);

  // A result that is not taken stays put.
  `ZLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_audio_out), "stalled result changed")

  // After an item is taken the block is busy with it.
  `ZLP_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "accepted a second item at once")

  // A result never appears in the cycle right after an item is taken.
  `ZLP_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid), "result came too soon")

endmodule

bind zdf_ladder_lowpass_unit zlp_checker u_zlp_checker (.*);
